>>> rtl/cmoc_pkg.sv
package cmoc_pkg;

    // Field and datapath widths
    localparam int IN_W     = 18;   // signed Q1.16 input component
    localparam int PROD_W   = 36;   // signed component product, Q3.32
    localparam int COMP_W   = 38;   // signed misorientation component
    localparam int PAIR_W   = 39;   // signed pair sum or difference
    localparam int QUAD_W   = 40;   // signed four-term sum
    localparam int PMAG_W   = 38;   // pair magnitude
    localparam int QMAG_W   = 39;   // four-term magnitude
    localparam int CMAG_W   = 37;   // component magnitude
    localparam int HALF_W   = 19;   // split point of a pair magnitude
    localparam int K_W      = 24;   // width of the sqrt(1/2) constant
    localparam int PPROD_W  = HALF_W + K_W;
    localparam int CAND_W   = 62;   // candidate magnitude in Q.56
    localparam int OUT_W    = 17;   // unsigned Q1.16 result

    // Counts
    localparam int NUM_Q     = 4;
    localparam int NUM_PROD  = 16;
    localparam int NUM_PAIRS = 6;
    localparam int NUM_PTERM = 2 * NUM_PAIRS;
    localparam int NUM_QUAD  = 8;

    // Scaling and rounding
    localparam logic [K_W-1:0] HALF_ROOT2_Q24 = 24'd11863283;
    localparam int QUAD_SHIFT  = 23;
    localparam int COMP_SHIFT  = 24;
    localparam int ROUND_SHIFT = 40;
    localparam int RSH_W       = CAND_W - ROUND_SHIFT;
    localparam logic [OUT_W-1:0] ONE_Q16 = 17'd65536;

    // Component index pairs for the 90-degree candidates (a=0, b=1, c=2, d=3)
    localparam logic [1:0] PAIR_FIRST  [NUM_PAIRS] = '{2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1};
    localparam logic [1:0] PAIR_SECOND [NUM_PAIRS] = '{2'd1, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2};

    typedef logic signed [IN_W-1:0]   in_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [CAND_W-1:0]        cand_t;
    typedef logic [OUT_W-1:0]         res_t;

    function automatic cand_t cand_max(input cand_t x, input cand_t y);
        return (x > y) ? x : y;
    endfunction

endpackage

>>> rtl/cmoc_qmul.sv
// Quaternion product q1 * conj(q2): one product stage, one sum stage
module cmoc_qmul
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  cmoc_pkg::in_t    q1 [cmoc_pkg::NUM_Q],
    input  cmoc_pkg::in_t    q2 [cmoc_pkg::NUM_Q],
    output logic             valid_out,
    output cmoc_pkg::comp_t  comp [cmoc_pkg::NUM_Q]
);

    // Operand indices of the sixteen products (w=0, x=1, y=2, z=3)
    localparam logic [1:0] P_LEFT  [cmoc_pkg::NUM_PROD] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd2, 2'd1, 2'd3, 2'd0};
    localparam logic [1:0] P_RIGHT [cmoc_pkg::NUM_PROD] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd2, 2'd3, 2'd1,
        2'd1, 2'd2, 2'd0, 2'd3};

    logic            prod_valid_reg;
    logic            comp_valid_reg;
    cmoc_pkg::prod_t prod_next [cmoc_pkg::NUM_PROD];
    cmoc_pkg::prod_t prod_reg  [cmoc_pkg::NUM_PROD];
    cmoc_pkg::comp_t comp_next [cmoc_pkg::NUM_Q];
    cmoc_pkg::comp_t comp_reg  [cmoc_pkg::NUM_Q];

    // Form all component products
    always_comb
    begin
        for (int i = 0; i < cmoc_pkg::NUM_PROD; i++)
        begin
            prod_next[i] = q1[P_LEFT[i]] * q2[P_RIGHT[i]];
        end
    end

    // Sum products: a takes all plus, b c d alternate signs
    always_comb
    begin
        comp_next[0] = cmoc_pkg::COMP_W'(prod_reg[0]) + cmoc_pkg::COMP_W'(prod_reg[1])
                     + cmoc_pkg::COMP_W'(prod_reg[2]) + cmoc_pkg::COMP_W'(prod_reg[3]);
        for (int k = 1; k < cmoc_pkg::NUM_Q; k++)
        begin
            comp_next[k] = cmoc_pkg::COMP_W'(prod_reg[4*k])
                         - cmoc_pkg::COMP_W'(prod_reg[4*k+1])
                         + cmoc_pkg::COMP_W'(prod_reg[4*k+2])
                         - cmoc_pkg::COMP_W'(prod_reg[4*k+3]);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            comp_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid_in;
            comp_valid_reg <= prod_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        comp_reg <= comp_next;
    end

    assign valid_out = comp_valid_reg;
    assign comp      = comp_reg;

endmodule

>>> rtl/cmoc_cand.sv
// Symmetry candidates: magnitudes, sqrt(1/2) scaling, alignment to Q.56
module cmoc_cand
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  cmoc_pkg::comp_t  comp [cmoc_pkg::NUM_Q],
    output logic             valid_out,
    output cmoc_pkg::cand_t  pair_term [cmoc_pkg::NUM_PTERM],
    output cmoc_pkg::cand_t  quad_term,
    output cmoc_pkg::cand_t  comp_term
);

    localparam int PW = cmoc_pkg::PAIR_W;
    localparam int QW = cmoc_pkg::QUAD_W;

    logic mag_valid_reg;
    logic prod_valid_reg;
    logic term_valid_reg;

    // Stage A: pair, four-term and component magnitudes
    logic signed [PW-1:0]         pair_sum  [cmoc_pkg::NUM_PTERM];
    logic signed [QW-1:0]         quad_sum  [cmoc_pkg::NUM_QUAD];
    logic [cmoc_pkg::PMAG_W-1:0]  pmag_next [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::PMAG_W-1:0]  pmag_reg  [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::QMAG_W-1:0]  qmag_next [cmoc_pkg::NUM_QUAD];
    logic [cmoc_pkg::QMAG_W-1:0]  qmag_reg  [cmoc_pkg::NUM_QUAD];
    logic [cmoc_pkg::CMAG_W-1:0]  cmag_next [cmoc_pkg::NUM_Q];
    logic [cmoc_pkg::CMAG_W-1:0]  cmag_reg  [cmoc_pkg::NUM_Q];

    // Stage B: split constant products, group maxima
    logic [cmoc_pkg::PPROD_W-1:0] phi_next  [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::PPROD_W-1:0] phi_reg   [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::PPROD_W-1:0] plo_next  [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::PPROD_W-1:0] plo_reg   [cmoc_pkg::NUM_PTERM];
    logic [cmoc_pkg::QMAG_W-1:0]  qlvl1     [4];
    logic [cmoc_pkg::QMAG_W-1:0]  qlvl2     [2];
    logic [cmoc_pkg::QMAG_W-1:0]  qmax_next;
    logic [cmoc_pkg::QMAG_W-1:0]  qmax_reg;
    logic [cmoc_pkg::CMAG_W-1:0]  clvl1     [2];
    logic [cmoc_pkg::CMAG_W-1:0]  cmax_next;
    logic [cmoc_pkg::CMAG_W-1:0]  cmax_reg;

    // Stage C: candidates in Q.56
    cmoc_pkg::cand_t pterm_next [cmoc_pkg::NUM_PTERM];
    cmoc_pkg::cand_t pterm_reg  [cmoc_pkg::NUM_PTERM];
    cmoc_pkg::cand_t qterm_next;
    cmoc_pkg::cand_t qterm_reg;
    cmoc_pkg::cand_t cterm_next;
    cmoc_pkg::cand_t cterm_reg;

    // Build pair sums and differences, then take magnitudes
    always_comb
    begin
        for (int k = 0; k < cmoc_pkg::NUM_PAIRS; k++)
        begin
            pair_sum[2*k]   = PW'(comp[cmoc_pkg::PAIR_FIRST[k]])
                            + PW'(comp[cmoc_pkg::PAIR_SECOND[k]]);
            pair_sum[2*k+1] = PW'(comp[cmoc_pkg::PAIR_FIRST[k]])
                            - PW'(comp[cmoc_pkg::PAIR_SECOND[k]]);
        end
        for (int i = 0; i < cmoc_pkg::NUM_PTERM; i++)
        begin
            pmag_next[i] = pair_sum[i][PW-1] ? cmoc_pkg::PMAG_W'(-pair_sum[i])
                                             : cmoc_pkg::PMAG_W'(pair_sum[i]);
        end
    end

    // Build all eight sign patterns of a +- b +- c +- d
    always_comb
    begin
        for (int i = 0; i < cmoc_pkg::NUM_QUAD; i++)
        begin
            quad_sum[i] = QW'(comp[0])
                        + (i[2] ? -QW'(comp[1]) : QW'(comp[1]))
                        + (i[1] ? -QW'(comp[2]) : QW'(comp[2]))
                        + (i[0] ? -QW'(comp[3]) : QW'(comp[3]));
            qmag_next[i] = quad_sum[i][QW-1] ? cmoc_pkg::QMAG_W'(-quad_sum[i])
                                             : cmoc_pkg::QMAG_W'(quad_sum[i]);
        end
    end

    // Take component magnitudes
    always_comb
    begin
        for (int k = 0; k < cmoc_pkg::NUM_Q; k++)
        begin
            cmag_next[k] = comp[k][cmoc_pkg::COMP_W-1] ? cmoc_pkg::CMAG_W'(-comp[k])
                                                       : cmoc_pkg::CMAG_W'(comp[k]);
        end
    end

    // Scale pair magnitudes by sqrt(1/2) in two halves
    always_comb
    begin
        for (int i = 0; i < cmoc_pkg::NUM_PTERM; i++)
        begin
            phi_next[i] = cmoc_pkg::PPROD_W'(pmag_reg[i][cmoc_pkg::PMAG_W-1:cmoc_pkg::HALF_W])
                        * cmoc_pkg::PPROD_W'(cmoc_pkg::HALF_ROOT2_Q24);
            plo_next[i] = cmoc_pkg::PPROD_W'(pmag_reg[i][cmoc_pkg::HALF_W-1:0])
                        * cmoc_pkg::PPROD_W'(cmoc_pkg::HALF_ROOT2_Q24);
        end
    end

    // Reduce four-term and component magnitudes to one maximum each
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qlvl1[i] = (qmag_reg[2*i] > qmag_reg[2*i+1]) ? qmag_reg[2*i] : qmag_reg[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            qlvl2[i] = (qlvl1[2*i] > qlvl1[2*i+1]) ? qlvl1[2*i] : qlvl1[2*i+1];
            clvl1[i] = (cmag_reg[2*i] > cmag_reg[2*i+1]) ? cmag_reg[2*i] : cmag_reg[2*i+1];
        end
        qmax_next = (qlvl2[0] > qlvl2[1]) ? qlvl2[0] : qlvl2[1];
        cmax_next = (clvl1[0] > clvl1[1]) ? clvl1[0] : clvl1[1];
    end

    // Recombine halves and align all candidates to Q.56
    always_comb
    begin
        for (int i = 0; i < cmoc_pkg::NUM_PTERM; i++)
        begin
            pterm_next[i] = (cmoc_pkg::CAND_W'(phi_reg[i]) << cmoc_pkg::HALF_W)
                          + cmoc_pkg::CAND_W'(plo_reg[i]);
        end
        qterm_next = cmoc_pkg::CAND_W'(qmax_reg) << cmoc_pkg::QUAD_SHIFT;
        cterm_next = cmoc_pkg::CAND_W'(cmax_reg) << cmoc_pkg::COMP_SHIFT;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
        end
        else
        begin
            mag_valid_reg  <= valid_in;
            prod_valid_reg <= mag_valid_reg;
            term_valid_reg <= prod_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        pmag_reg  <= pmag_next;
        qmag_reg  <= qmag_next;
        cmag_reg  <= cmag_next;
        phi_reg   <= phi_next;
        plo_reg   <= plo_next;
        qmax_reg  <= qmax_next;
        cmax_reg  <= cmax_next;
        pterm_reg <= pterm_next;
        qterm_reg <= qterm_next;
        cterm_reg <= cterm_next;
    end

    assign valid_out = term_valid_reg;
    assign pair_term = pterm_reg;
    assign quad_term = qterm_reg;
    assign comp_term = cterm_reg;

endmodule

>>> rtl/cmoc_max.sv
// Registered maximum tree over all candidates, then round and saturate
module cmoc_max
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  cmoc_pkg::cand_t  pair_term [cmoc_pkg::NUM_PTERM],
    input  cmoc_pkg::cand_t  quad_term,
    input  cmoc_pkg::cand_t  comp_term,
    output logic             done,
    output cmoc_pkg::res_t   result
);

    localparam int NUM_GRP = cmoc_pkg::NUM_PTERM / 4 + 1;
    localparam cmoc_pkg::cand_t ROUND_BIAS =
        cmoc_pkg::CAND_W'(1) << (cmoc_pkg::ROUND_SHIFT - 1);

    logic                        grp_valid_reg;
    logic                        max_valid_reg;
    logic                        done_reg;
    cmoc_pkg::cand_t             grp_next [NUM_GRP];
    cmoc_pkg::cand_t             grp_reg  [NUM_GRP];
    cmoc_pkg::cand_t             max_next;
    cmoc_pkg::cand_t             max_reg;
    cmoc_pkg::cand_t             rnd_sum;
    logic [cmoc_pkg::RSH_W-1:0]  rnd_val;
    cmoc_pkg::res_t              result_next;
    cmoc_pkg::res_t              result_reg;

    // Reduce pair candidates in groups of four; fold four-term with component
    always_comb
    begin
        for (int g = 0; g < NUM_GRP - 1; g++)
        begin
            grp_next[g] = cmoc_pkg::cand_max(
                cmoc_pkg::cand_max(pair_term[4*g],   pair_term[4*g+1]),
                cmoc_pkg::cand_max(pair_term[4*g+2], pair_term[4*g+3]));
        end
        grp_next[NUM_GRP-1] = cmoc_pkg::cand_max(quad_term, comp_term);
    end

    // Reduce the group maxima
    always_comb
    begin
        max_next = cmoc_pkg::cand_max(cmoc_pkg::cand_max(grp_reg[0], grp_reg[1]),
                                      cmoc_pkg::cand_max(grp_reg[2], grp_reg[3]));
    end

    // Round to nearest Q1.16 with ties up, saturate at one
    always_comb
    begin
        rnd_sum = max_reg + ROUND_BIAS;
        rnd_val = rnd_sum[cmoc_pkg::CAND_W-1:cmoc_pkg::ROUND_SHIFT];
        if (rnd_val > cmoc_pkg::RSH_W'(cmoc_pkg::ONE_Q16))
        begin
            result_next = cmoc_pkg::ONE_Q16;
        end
        else
        begin
            result_next = rnd_val[cmoc_pkg::OUT_W-1:0];
        end
    end

    // Advance valid bits and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            max_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= valid_in;
            max_valid_reg <= grp_valid_reg;
            done_reg      <= max_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        grp_reg    <= grp_next;
        max_reg    <= max_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/cubic_misorientation_cos_half.sv
// done pulses when a transaction accepted at a clock edge has passed all
// 8 register stages (products, components, magnitudes, constant products,
// alignment, two maximum-tree levels, rounding). Throughput: one transaction
// per cycle; busy is always low. The receiver cannot stall; each result shows
// for one cycle with done. Reset (rst_n, async, active low) clears all valid bits.
module cubic_misorientation_cos_half
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [17:0]            q1_w,
    input  logic signed [17:0]            q1_x,
    input  logic signed [17:0]            q1_y,
    input  logic signed [17:0]            q1_z,
    input  logic signed [17:0]            q2_w,
    input  logic signed [17:0]            q2_x,
    input  logic signed [17:0]            q2_y,
    input  logic signed [17:0]            q2_z,
    output logic                          done,
    output logic [16:0]                   cos_half_min_angle
);

    logic             accept;
    cmoc_pkg::in_t    q1 [cmoc_pkg::NUM_Q];
    cmoc_pkg::in_t    q2 [cmoc_pkg::NUM_Q];
    logic             comp_valid;
    cmoc_pkg::comp_t  comp [cmoc_pkg::NUM_Q];
    logic             term_valid;
    cmoc_pkg::cand_t  pair_term [cmoc_pkg::NUM_PTERM];
    cmoc_pkg::cand_t  quad_term;
    cmoc_pkg::cand_t  comp_term;
    cmoc_pkg::res_t   result;

    // Pipeline never blocks
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Gather quaternion components, scalar part first
    assign q1[0] = q1_w;
    assign q1[1] = q1_x;
    assign q1[2] = q1_y;
    assign q1[3] = q1_z;
    assign q2[0] = q2_w;
    assign q2[1] = q2_x;
    assign q2[2] = q2_y;
    assign q2[3] = q2_z;

    cmoc_qmul u_qmul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .q1        (q1),
        .q2        (q2),
        .valid_out (comp_valid),
        .comp      (comp)
    );

    cmoc_cand u_cand
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (comp_valid),
        .comp      (comp),
        .valid_out (term_valid),
        .pair_term (pair_term),
        .quad_term (quad_term),
        .comp_term (comp_term)
    );

    cmoc_max u_max
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (term_valid),
        .pair_term (pair_term),
        .quad_term (quad_term),
        .comp_term (comp_term),
        .done      (done),
        .result    (result)
    );

    assign cos_half_min_angle = result;

endmodule
